[sv/tmt_pkg.sv]
`default_nettype none

package tmt_pkg;

   // sizing
   localparam int MAX_ARGS  = 64;
   localparam int BUF_DEPTH = 4096;

   localparam int OFF_W  = $clog2(BUF_DEPTH);        // buffer slot
   localparam int WOFF_W = $clog2(BUF_DEPTH) + 1;    // write pointer, holds BUF_DEPTH
   localparam int IDX_W  = $clog2(MAX_ARGS);         // argument index
   localparam int ARGC_W = $clog2(MAX_ARGS) + 1;     // argument count, holds MAX_ARGS
   localparam int TAG_W  = 31;

   localparam logic [TAG_W-1:0] TAG_MAX = {TAG_W{1'b1}};

   // characters
   localparam logic [7:0] CH_QUERY  = 8'h3F;  // ?
   localparam logic [7:0] CH_BANG   = 8'h21;  // !
   localparam logic [7:0] CH_HASH   = 8'h23;  // #
   localparam logic [7:0] CH_LBRACK = 8'h5B;  // [
   localparam logic [7:0] CH_RBRACK = 8'h5D;  // ]
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;  // _
   localparam logic [7:0] CH_AT     = 8'h40;  // @
   localparam logic [7:0] CH_E      = 8'h65;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ESCAPE = 8'd27;
   localparam logic [7:0] CH_NUL    = 8'h00;

   // message type codes
   localparam logic [1:0] MSG_NONE    = 2'd0;
   localparam logic [1:0] MSG_REQUEST = 2'd1;
   localparam logic [1:0] MSG_REPLY   = 2'd2;
   localparam logic [1:0] MSG_INFORM  = 2'd3;

   typedef enum logic [2:0] {
      MODE_FRESH = 3'd0,
      MODE_NAME  = 3'd1,
      MODE_TAG   = 3'd2,
      MODE_GAP   = 3'd3,
      MODE_ARG   = 3'd4,
      MODE_ESC   = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      EV_SKIP       = 3'd0,
      EV_STORE      = 3'd1,
      EV_CLOSE      = 3'd2,
      EV_CLOSE_DONE = 3'd3,
      EV_DONE       = 3'd4,
      EV_TAG_ERR    = 3'd5
   } event_type;

   typedef struct packed {
      event_type         event_res;
      logic [7:0]        out_byte;
      logic [OFF_W-1:0]  out_offset;
      logic              arg_start;
      logic [IDX_W-1:0]  arg_index;
      logic              arg_escaped;
      logic [TAG_W-1:0]  tag_value;
      logic              tag_present;
      logic [1:0]        msg_type;
      logic              overflow;
   } result_type;

endpackage

`default_nettype wire

[sv/tmt_parse.sv]
`default_nettype none

// Parser state and the combinational step that consumes one byte.
module tmt_parse (
   input  wire                clock,
   input  wire                reset,
   input  wire                step_en,
   input  wire [7:0]          in_byte,
   output tmt_pkg::result_type result
);
   import tmt_pkg::*;

   mode_type          mode_ff, mode_in;
   logic [WOFF_W-1:0] woff_ff, woff_in;
   logic [ARGC_W-1:0] argc_ff, argc_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic              tag_seen_ff, tag_seen_in;
   logic              esc_ff, esc_in;
   logic [1:0]        type_ff, type_in;
   logic              ovf_ff, ovf_in;

   logic              done;
   logic              take;
   logic              slot_full, args_full;
   logic [OFF_W-1:0]  slot_off;
   logic [IDX_W-1:0]  cur_idx;
   logic              is_mark, is_space, is_eol, is_digit;
   logic [34:0]       tag_x10;
   logic [7:0]        esc_val;

   assign slot_full = (woff_ff >= WOFF_W'(BUF_DEPTH));
   assign slot_off  = slot_full ? OFF_W'(BUF_DEPTH - 1) : woff_ff[OFF_W-1:0];
   assign args_full = (argc_ff >= ARGC_W'(MAX_ARGS));
   assign cur_idx   = args_full ? IDX_W'(MAX_ARGS - 1) : argc_ff[IDX_W-1:0];

   assign is_mark  = (in_byte == CH_QUERY) || (in_byte == CH_BANG) || (in_byte == CH_HASH);
   assign is_space = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
   assign is_eol   = (in_byte == CH_LF) || (in_byte == CH_CR);
   assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);

   // tag*10 + digit; anything past 31 bits saturates
   assign tag_x10 = ({4'b0, tag_ff} << 3) + ({4'b0, tag_ff} << 1)
                    + {27'b0, in_byte - CH_ZERO};

   always_comb begin
      case (in_byte)
         CH_E:     esc_val = CH_ESCAPE;
         CH_N:     esc_val = CH_LF;
         CH_R:     esc_val = CH_CR;
         CH_T:     esc_val = CH_TAB;
         CH_ZERO:  esc_val = CH_NUL;
         CH_UNDER: esc_val = CH_SPACE;
         default:  esc_val = in_byte;
      endcase
   end

   // next mode
   always_comb begin
      mode_in = mode_ff;
      case (mode_ff)
         MODE_FRESH: begin
            if (is_mark) mode_in = MODE_NAME;
         end
         MODE_NAME, MODE_ARG: begin
            if (in_byte == CH_LBRACK && mode_ff == MODE_NAME) mode_in = MODE_TAG;
            else if (is_space) mode_in = MODE_GAP;
            else if (is_eol) mode_in = mode_ff;
            else if (in_byte == CH_BSLASH && mode_ff == MODE_ARG) mode_in = MODE_ESC;
         end
         MODE_TAG: begin
            if (!is_digit && in_byte == CH_RBRACK) mode_in = MODE_GAP;
         end
         MODE_GAP: begin
            if (!is_space && !is_eol)
               mode_in = (in_byte == CH_BSLASH) ? MODE_ESC : MODE_ARG;
         end
         MODE_ESC: mode_in = MODE_ARG;
         default:  mode_in = MODE_FRESH;
      endcase
   end

   // result and datapath state
   always_comb begin
      result           = '0;
      result.event_res = EV_SKIP;
      woff_in     = woff_ff;
      argc_in     = argc_ff;
      tag_in      = tag_ff;
      tag_seen_in = tag_seen_ff;
      esc_in      = esc_ff;
      type_in     = type_ff;
      ovf_in      = ovf_ff;
      done        = 1'b0;
      take        = 1'b0;

      case (mode_ff)
         MODE_FRESH: begin
            if (is_mark) begin
               type_in = (in_byte == CH_QUERY) ? MSG_REQUEST :
                         (in_byte == CH_BANG)  ? MSG_REPLY : MSG_INFORM;
               if (args_full) ovf_in = 1'b1;
               esc_in           = 1'b0;
               result.arg_start = 1'b1;
               result.arg_index = cur_idx;
               result.event_res = EV_STORE;
               result.out_byte  = in_byte;
               take             = 1'b1;
            end
         end
         MODE_NAME, MODE_ARG: begin
            result.arg_index   = cur_idx;
            result.arg_escaped = esc_ff;
            if (in_byte == CH_LBRACK && mode_ff == MODE_NAME) begin
               result.event_res = EV_CLOSE;
               take        = 1'b1;
               tag_in      = '0;
               tag_seen_in = 1'b1;
               if (!args_full) argc_in = argc_ff + 1'b1;
            end else if (is_space) begin
               result.event_res = EV_CLOSE;
               take = 1'b1;
               if (!args_full) argc_in = argc_ff + 1'b1;
            end else if (is_eol) begin
               result.event_res = EV_CLOSE_DONE;
               take = 1'b1;
               done = 1'b1;
               if (!args_full) argc_in = argc_ff + 1'b1;
            end else if (in_byte == CH_BSLASH && mode_ff == MODE_ARG) begin
               // escape lead-in, nothing stored yet
            end else begin
               result.event_res = EV_STORE;
               result.out_byte  = in_byte;
               take = 1'b1;
            end
         end
         MODE_TAG: begin
            if (is_digit) begin
               tag_in = (tag_x10 > {4'b0, TAG_MAX}) ? TAG_MAX : tag_x10[TAG_W-1:0];
            end else if (in_byte != CH_RBRACK) begin
               result.event_res = EV_TAG_ERR;
               done = 1'b1;
            end
         end
         MODE_GAP: begin
            if (is_eol) begin
               result.event_res = EV_DONE;
               done = 1'b1;
            end else if (!is_space) begin
               if (args_full) ovf_in = 1'b1;
               esc_in           = 1'b0;
               result.arg_start = 1'b1;
               result.arg_index = cur_idx;
               if (in_byte == CH_BSLASH) begin
                  result.out_offset = slot_off;
               end else begin
                  result.event_res = EV_STORE;
                  result.out_byte  = in_byte;
                  take = 1'b1;
               end
            end
         end
         MODE_ESC: begin
            result.arg_index   = cur_idx;
            result.arg_escaped = 1'b1;
            esc_in             = 1'b1;
            if (in_byte != CH_AT) begin
               result.event_res = EV_STORE;
               result.out_byte  = esc_val;
               take = 1'b1;
            end
         end
         default: ;
      endcase

      if (take) begin
         result.out_offset = slot_off;
         if (slot_full) ovf_in = 1'b1;
         else woff_in = woff_ff + 1'b1;
      end

      result.tag_value   = tag_in;
      result.tag_present = tag_seen_in;
      result.msg_type    = type_in;
      result.overflow    = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step_en && done)) begin
         mode_ff     <= MODE_FRESH;
         woff_ff     <= '0;
         argc_ff     <= '0;
         tag_ff      <= '0;
         tag_seen_ff <= 1'b0;
         esc_ff      <= 1'b0;
         type_ff     <= MSG_NONE;
         ovf_ff      <= 1'b0;
      end else if (step_en) begin
         mode_ff     <= mode_in;
         woff_ff     <= woff_in;
         argc_ff     <= argc_in;
         tag_ff      <= tag_in;
         tag_seen_ff <= tag_seen_in;
         esc_ff      <= esc_in;
         type_ff     <= type_in;
         ovf_ff      <= ovf_in;
      end
   end

   a_done_fresh: assert property (@(posedge clock) disable iff (reset)
      step_en && done |=> mode_ff == MODE_FRESH && woff_ff == '0)
      else $error("parser not fresh after message end");

   a_tag_err_mode: assert property (@(posedge clock) disable iff (reset)
      result.event_res == EV_TAG_ERR |-> mode_ff == MODE_TAG && tag_seen_ff)
      else $error("tag error outside a tag");

   a_woff_bound: assert property (@(posedge clock) disable iff (reset)
      woff_ff <= WOFF_W'(BUF_DEPTH))
      else $error("write offset beyond buffer depth");

endmodule

`default_nettype wire

[sv/text_line_message_tokenizer.sv]
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_in_byte, one raw byte per word
// rsp_      out        rsp_valid/rsp_stall  decoded byte, offset, argument and tag status
//
// One byte per cycle sustained while rsp_stall is low.
// Input register -> parse step (state update) -> result register; every byte gives one word.
// Parser state advances only when the input register moves into the result register.
// Reset (synchronous) empties both registers and makes the parser fresh.
// rsp_stall holds the result register; req_stall rises only when both registers are full.
module text_line_message_tokenizer (
   input  wire                           clock,
   input  wire                           reset,

   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire [7:0]                     req_in_byte,

   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [2:0]                    rsp_event_res,
   output logic [7:0]                    rsp_out_byte,
   output logic [tmt_pkg::OFF_W-1:0]     rsp_out_offset,
   output logic                          rsp_arg_start,
   output logic [tmt_pkg::IDX_W-1:0]     rsp_arg_index,
   output logic                          rsp_arg_escaped,
   output logic [tmt_pkg::TAG_W-1:0]     rsp_tag_value,
   output logic                          rsp_tag_present,
   output logic [1:0]                    rsp_msg_type,
   output logic                          rsp_overflow
);
   import tmt_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type step_res;
   logic       req_take;
   logic       move;   // input register hands its byte to the parser this cycle

   assign move      = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !move;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (move ? 1'b0 : in_valid_ff);
   assign out_valid_in = move ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   tmt_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step_en (move),
      .in_byte (in_byte_ff),
      .result  (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) in_byte_ff <= req_in_byte;
      if (move)     out_ff     <= step_res;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_event_res   = out_ff.event_res;
   assign rsp_out_byte    = out_ff.out_byte;
   assign rsp_out_offset  = out_ff.out_offset;
   assign rsp_arg_start   = out_ff.arg_start;
   assign rsp_arg_index   = out_ff.arg_index;
   assign rsp_arg_escaped = out_ff.arg_escaped;
   assign rsp_tag_value   = out_ff.tag_value;
   assign rsp_tag_present = out_ff.tag_present;
   assign rsp_msg_type    = out_ff.msg_type;
   assign rsp_overflow    = out_ff.overflow;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_take |-> !in_valid_ff || move)
      else $error("input register overwritten while full");

   a_rsp_from_move: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(move))
      else $error("result word appeared without a parse step");

   a_start_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_arg_start |->
         out_ff.event_res == EV_STORE || out_ff.event_res == EV_SKIP)
      else $error("argument start on a closing event");

endmodule

`default_nettype wire
